// ===== sv/periodic_task_round_robin_dispatcher_top_defines.svh =====
// Assertion macros shared by the dispatcher RTL.
`ifndef PERIODIC_TASK_ROUND_ROBIN_DISPATCHER_TOP_DEFINES_SVH
`define PERIODIC_TASK_ROUND_ROBIN_DISPATCHER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define PTRRD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked out of reset.
`define PTRRD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PTRRD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PTRRD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/ptrrd_pkg.sv =====
// Types, constants and the control program of the task dispatcher.
package ptrrd_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int SLOT_W     = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int INTV_W     = 16;
	localparam int TIMER_W    = 32;
	localparam int STEP_W     = 4;

	// operation codes of an input request
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_POLL = 1'b1;

	// datapath micro-operations
	localparam logic [2:0] UOP_NOP       = 3'd0;
	localparam logic [2:0] UOP_ACCEPT    = 3'd1;
	localparam logic [2:0] UOP_CLR_SLOT  = 3'd2;
	localparam logic [2:0] UOP_LAUNCH    = 3'd3;
	localparam logic [2:0] UOP_MARK      = 3'd4;
	localparam logic [2:0] UOP_INC_SLOT  = 3'd5;
	localparam logic [2:0] UOP_EMIT_TICK = 3'd6;
	localparam logic [2:0] UOP_POLL      = 3'd7;

	// jump conditions
	localparam logic [2:0] COND_NONE     = 3'd0;
	localparam logic [2:0] COND_ALWAYS   = 3'd1;
	localparam logic [2:0] COND_NOSTART  = 3'd2;
	localparam logic [2:0] COND_POLL     = 3'd3;
	localparam logic [2:0] COND_SLOT_END = 3'd4;
	localparam logic [2:0] COND_SKIP     = 3'd5;
	localparam logic [2:0] COND_BUSY     = 3'd6;

	// program steps
	localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
	localparam logic [STEP_W-1:0] STEP_DECODE = 4'd1;
	localparam logic [STEP_W-1:0] STEP_CHECK  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_LAUNCH = 4'd3;
	localparam logic [STEP_W-1:0] STEP_WAIT   = 4'd4;
	localparam logic [STEP_W-1:0] STEP_MARK   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_INC    = 4'd6;
	localparam logic [STEP_W-1:0] STEP_SPARE  = 4'd7;
	localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd8;
	localparam logic [STEP_W-1:0] STEP_POLL   = 4'd9;

	typedef struct packed {
		logic [2:0]        uop;
		logic [2:0]        cond;
		logic [STEP_W-1:0] target;
	} ctrl_word_t;

	typedef struct packed {
		logic busy;
		logic rem_zero;
	} rem_status_t;

	function automatic ctrl_word_t control_rom(input logic [STEP_W-1:0] step);
		ctrl_word_t w;
		case (step)
			STEP_IDLE:   w = '{UOP_ACCEPT,    COND_NOSTART,  STEP_IDLE};
			STEP_DECODE: w = '{UOP_CLR_SLOT,  COND_POLL,     STEP_POLL};
			STEP_CHECK:  w = '{UOP_NOP,       COND_SLOT_END, STEP_EMIT};
			STEP_LAUNCH: w = '{UOP_LAUNCH,    COND_SKIP,     STEP_INC};
			STEP_WAIT:   w = '{UOP_NOP,       COND_BUSY,     STEP_WAIT};
			STEP_MARK:   w = '{UOP_MARK,      COND_NONE,     STEP_IDLE};
			STEP_INC:    w = '{UOP_INC_SLOT,  COND_ALWAYS,   STEP_CHECK};
			STEP_SPARE:  w = '{UOP_NOP,       COND_ALWAYS,   STEP_IDLE};
			STEP_EMIT:   w = '{UOP_EMIT_TICK, COND_ALWAYS,   STEP_IDLE};
			STEP_POLL:   w = '{UOP_POLL,      COND_ALWAYS,   STEP_IDLE};
			default:     w = '{UOP_NOP,       COND_ALWAYS,   STEP_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic [INTV_W-1:0] interval_reset(input logic [SLOT_W-1:0] slot);
		logic [INTV_W-1:0] v;
		case (slot)
			3'd4:    v = 16'd500;
			3'd5:    v = 16'd100;
			3'd6:    v = 16'd500;
			3'd7:    v = 16'd3000;
			default: v = 16'd1000;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/ptrrd_rem_unit.sv =====
// Bit-serial restoring remainder unit: 32-bit dividend, 16-bit divisor.
module ptrrd_rem_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [ptrrd_pkg::TIMER_W-1:0]      dividend,
	input  logic [ptrrd_pkg::INTV_W-1:0]       divisor,
	output ptrrd_pkg::rem_status_t             status
);

	logic                               busy_q;
	logic [4:0]                         cnt_q;
	logic [ptrrd_pkg::INTV_W-1:0]       rem_q;
	logic [ptrrd_pkg::INTV_W-1:0]       dsr_q;
	logic [ptrrd_pkg::TIMER_W-1:0]      dvd_q;
	logic [ptrrd_pkg::INTV_W:0]         shifted;
	logic [ptrrd_pkg::INTV_W:0]         diff;
	logic                               fits;

	assign shifted = {rem_q, dvd_q[ptrrd_pkg::TIMER_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	// one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[ptrrd_pkg::INTV_W-1:0] : shifted[ptrrd_pkg::INTV_W-1:0];
			dvd_q <= {dvd_q[ptrrd_pkg::TIMER_W-2:0], 1'b0};
		end
	end

	assign status.busy     = busy_q;
	assign status.rem_zero = (rem_q == '0);

endmodule

// ===== sv/periodic_task_round_robin_dispatcher_top.sv =====
// Top level of the periodic task round-robin dispatcher.
//
// Usage: raise start with operation, timer_value and enable_mask; the request
// is taken at the clock edge where start is high and busy is low. busy stays
// high until the result is out. Each request yields one result, shown for a
// single cycle with done high: dispatch_valid, task_index and ready_mask.
// A tick (operation 0) sets the ready flag of every enabled slot below
// NUM_TASKS whose interval divides timer_value; its result carries
// dispatch_valid 0 and task_index 0. A poll (operation 1) examines the slot
// under the round-robin pointer, reports and clears its flag if set, then
// advances the pointer, wrapping at NUM_TASKS.
// A poll passes the decode and poll steps from accept to done, and busy falls
// as done rises, so the next request can be taken in the result cycle. A tick
// runs check, launch, wait, mark and increment for each enabled slot with a
// nonzero interval, and check, launch and increment for each skipped slot;
// the serial remainder unit (one bit per cycle) sets the wait step's length.
// Control is a ten-step program in a constant table; the step counter walks
// it, with conditional jumps on start, operation, slot end, skip and busy.
// Interval registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while idle, which the block does not enforce. An index
// of 8 or above is ignored. Reset clears ready flags, pointer and sequencer
// and loads the default intervals. The receiver cannot hold off done.
`include "periodic_task_round_robin_dispatcher_top_defines.svh"

module periodic_task_round_robin_dispatcher_top #(
	parameter int NUM_TASKS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  operation,
	input  logic [ptrrd_pkg::TIMER_W-1:0]         timer_value,
	input  logic [ptrrd_pkg::SLOT_COUNT-1:0]      enable_mask,
	output logic                                  done,
	output logic                                  dispatch_valid,
	output logic [ptrrd_pkg::SLOT_W-1:0]          task_index,
	output logic [ptrrd_pkg::SLOT_COUNT-1:0]      ready_mask,
	input  logic                                  cfg_we,
	input  logic [ptrrd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ptrrd_pkg::INTV_W-1:0]          cfg_data
);

	localparam logic [ptrrd_pkg::SLOT_W:0] TASK_COUNT = (ptrrd_pkg::SLOT_W+1)'(NUM_TASKS);

	logic [ptrrd_pkg::STEP_W-1:0]      step_q;
	logic [ptrrd_pkg::STEP_W-1:0]      step_d;
	ptrrd_pkg::ctrl_word_t             cw;
	logic                              jump;

	logic [ptrrd_pkg::INTV_W-1:0]      intervals_q [ptrrd_pkg::SLOT_COUNT];
	logic [ptrrd_pkg::SLOT_COUNT-1:0]  flags_q;
	logic [ptrrd_pkg::SLOT_W-1:0]      ptr_q;
	logic [ptrrd_pkg::SLOT_W:0]        slot_q;
	logic                              op_q;
	logic [ptrrd_pkg::TIMER_W-1:0]     timer_q;
	logic [ptrrd_pkg::SLOT_COUNT-1:0]  enable_q;
	logic                              done_q;
	logic                              dispatch_q;
	logic [ptrrd_pkg::SLOT_W-1:0]      index_q;

	logic [ptrrd_pkg::INTV_W-1:0]      cur_interval;
	logic                              slot_end;
	logic                              skip;
	logic                              rem_start;
	logic [ptrrd_pkg::SLOT_W:0]        ptr_next;
	ptrrd_pkg::rem_status_t            rem_stat;

	assign cw           = ptrrd_pkg::control_rom(step_q);
	assign cur_interval = intervals_q[slot_q[ptrrd_pkg::SLOT_W-1:0]];
	assign slot_end     = slot_q >= TASK_COUNT;
	assign skip         = !enable_q[slot_q[ptrrd_pkg::SLOT_W-1:0]] || (cur_interval == '0);
	assign rem_start    = (cw.uop == ptrrd_pkg::UOP_LAUNCH) && !skip;
	assign ptr_next     = {1'b0, ptr_q} + 1'b1;

	// Pick the jump condition named by the control word.
	always_comb begin
		case (cw.cond)
			ptrrd_pkg::COND_NONE:     jump = 1'b0;
			ptrrd_pkg::COND_ALWAYS:   jump = 1'b1;
			ptrrd_pkg::COND_NOSTART:  jump = !start;
			ptrrd_pkg::COND_POLL:     jump = (op_q == ptrrd_pkg::OP_POLL);
			ptrrd_pkg::COND_SLOT_END: jump = slot_end;
			ptrrd_pkg::COND_SKIP:     jump = skip;
			ptrrd_pkg::COND_BUSY:     jump = rem_stat.busy;
			default:                  jump = 1'b1;
		endcase
		step_d = jump ? cw.target : step_q + 1'b1;
	end

	// Advance the step counter; hold the control state of the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ptrrd_pkg::STEP_IDLE;
			flags_q <= '0;
			ptr_q   <= '0;
			slot_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			step_q <= step_d;
			done_q <= 1'b0;
			case (cw.uop)
				ptrrd_pkg::UOP_CLR_SLOT: slot_q <= '0;
				ptrrd_pkg::UOP_MARK: begin
					if (rem_stat.rem_zero) begin
						flags_q[slot_q[ptrrd_pkg::SLOT_W-1:0]] <= 1'b1;
					end
				end
				ptrrd_pkg::UOP_INC_SLOT:  slot_q <= slot_q + 1'b1;
				ptrrd_pkg::UOP_EMIT_TICK: done_q <= 1'b1;
				ptrrd_pkg::UOP_POLL: begin
					done_q         <= 1'b1;
					flags_q[ptr_q] <= 1'b0;
					ptr_q          <= (ptr_next >= TASK_COUNT) ?
						'0 : ptr_next[ptrrd_pkg::SLOT_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// Capture the request and the result payload.
	always_ff @(posedge clk) begin
		if (cw.uop == ptrrd_pkg::UOP_ACCEPT && start) begin
			op_q     <= operation;
			timer_q  <= timer_value;
			enable_q <= enable_mask;
		end
		if (cw.uop == ptrrd_pkg::UOP_EMIT_TICK) begin
			dispatch_q <= 1'b0;
			index_q    <= '0;
		end else if (cw.uop == ptrrd_pkg::UOP_POLL) begin
			dispatch_q <= flags_q[ptr_q];
			index_q    <= ptr_q;
		end
	end

	// Interval registers: reset to the default periods, write while idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ptrrd_pkg::SLOT_COUNT; i++) begin
				intervals_q[i] <= ptrrd_pkg::interval_reset(ptrrd_pkg::SLOT_W'(i));
			end
		end else if (cfg_we && cfg_index < ptrrd_pkg::CFG_IDX_W'(ptrrd_pkg::SLOT_COUNT)) begin
			intervals_q[cfg_index[ptrrd_pkg::SLOT_W-1:0]] <= cfg_data;
		end
	end

	ptrrd_rem_unit u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (timer_q),
		.divisor  (cur_interval),
		.status   (rem_stat)
	);

	assign busy           = (step_q != ptrrd_pkg::STEP_IDLE);
	assign done           = done_q;
	assign dispatch_valid = dispatch_q;
	assign task_index     = index_q;
	assign ready_mask     = flags_q;

	`PTRRD_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accept did not raise busy")
	`PTRRD_ASSERT_NXT(a_emit_done, clk, arst_n, (step_q == ptrrd_pkg::STEP_EMIT) || (step_q == ptrrd_pkg::STEP_POLL), done && !busy, "result step did not strobe done")
	`PTRRD_ASSERT_IMP(a_dispatch_clears, clk, arst_n, done && dispatch_valid, !ready_mask[task_index], "dispatched slot still ready")
	`PTRRD_ASSERT_IMP(a_rem_in_wait, clk, arst_n, rem_stat.busy, step_q == ptrrd_pkg::STEP_WAIT, "remainder unit busy outside wait step")

endmodule

// ===== test/tb.sv =====
// Self-checking testbench of the periodic task round-robin dispatcher.
module tb;
	import ptrrd_pkg::*;

	localparam int TASKS          = 8;
	localparam int ITEMS_PER_PLAN = 150;
	localparam int DRAIN_LIMIT    = 5000;
	localparam int PRINT_LIMIT    = 100;

	// One result of the dispatcher: what a tick or a poll leaves behind.
	typedef struct packed {
		logic              vld;
		logic [SLOT_W-1:0] idx;
		logic [SLOT_COUNT-1:0] rdy;
	} dispatch_t;

	// One row of the directed table. Rows with typed set carry a result that
	// can be read straight off the schedule; the rest rely on the predictor.
	typedef struct packed {
		logic                  op;
		logic [TIMER_W-1:0]    timer;
		logic [SLOT_COUNT-1:0] mask;
		logic                  typed;
		dispatch_t             res;
	} request_row_t;

	// Interval settings walked through by the random part, one per phase.
	typedef enum int {
		PLAN_MIN,
		PLAN_MAX,
		PLAN_TINY,
		PLAN_WIDE_ZERO,
		PLAN_MID,
		PLAN_COUNT
	} interval_plan_t;

	localparam int DIRECTED_ROWS = 21;
	localparam request_row_t DIRECTED [DIRECTED_ROWS] = '{
		// out of reset nothing is ready and the pointer sits on slot 0
		'{OP_POLL, 32'h0000_0000, 8'h00, 1'b1, '{1'b0, 3'd0, 8'h00}},
		// all-ones timer: no default interval divides it
		'{OP_TICK, 32'hFFFF_FFFF, 8'hFF, 1'b1, '{1'b0, 3'd0, 8'h00}},
		// timer zero with every slot disabled: nothing set
		'{OP_TICK, 32'h0000_0000, 8'h00, 1'b1, '{1'b0, 3'd0, 8'h00}},
		// timer zero with every slot enabled: every interval divides it
		'{OP_TICK, 32'h0000_0000, 8'hFF, 1'b1, '{1'b0, 3'd0, 8'hFF}},
		// walk the pointer round; poll ignores timer and enables
		'{OP_POLL, 32'hFFFF_FFFF, 8'h00, 1'b1, '{1'b1, 3'd1, 8'hFD}},
		'{OP_POLL, 32'h1234_5678, 8'hFF, 1'b1, '{1'b1, 3'd2, 8'hF9}},
		'{OP_POLL, 32'h0000_0000, 8'h00, 1'b1, '{1'b1, 3'd3, 8'hF1}},
		'{OP_POLL, 32'h0000_0000, 8'h00, 1'b1, '{1'b1, 3'd4, 8'hE1}},
		'{OP_POLL, 32'h0000_0000, 8'h00, 1'b1, '{1'b1, 3'd5, 8'hC1}},
		'{OP_POLL, 32'h0000_0000, 8'h00, 1'b1, '{1'b1, 3'd6, 8'h81}},
		'{OP_POLL, 32'h0000_0000, 8'h00, 1'b1, '{1'b1, 3'd7, 8'h01}},
		// pointer wraps back to slot 0
		'{OP_POLL, 32'h0000_0000, 8'h00, 1'b1, '{1'b1, 3'd0, 8'h00}},
		// slot not ready: no dispatch, pointer still moves
		'{OP_POLL, 32'h0000_0000, 8'h00, 1'b1, '{1'b0, 3'd1, 8'h00}},
		// only the 100-tick slot fires
		'{OP_TICK, 32'd100,       8'hFF, 1'b1, '{1'b0, 3'd0, 8'h20}},
		// slot 7 disabled, the others fire
		'{OP_TICK, 32'd3000,      8'h7F, 1'b1, '{1'b0, 3'd0, 8'h7F}},
		'{OP_TICK, 32'd6000,      8'h80, 1'b1, '{1'b0, 3'd0, 8'hFF}},
		'{OP_TICK, 32'd250,       8'hFF, 1'b0, '{1'b0, 3'd0, 8'h00}},
		'{OP_TICK, 32'd2000000000, 8'hA5, 1'b0, '{1'b0, 3'd0, 8'h00}},
		'{OP_POLL, 32'hA5A5_5A5A, 8'h3C, 1'b0, '{1'b0, 3'd0, 8'h00}},
		'{OP_POLL, 32'h5A5A_A5A5, 8'hC3, 1'b0, '{1'b0, 3'd0, 8'h00}},
		'{OP_TICK, 32'd1500,      8'h10, 1'b0, '{1'b0, 3'd0, 8'h00}}
	};

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  start       = 1'b0;
	logic                  operation   = OP_TICK;
	logic [TIMER_W-1:0]    timer_value = '0;
	logic [SLOT_COUNT-1:0] enable_mask = '0;
	logic                  cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [INTV_W-1:0]     cfg_data    = '0;
	logic                  busy;
	logic                  done;
	logic                  dispatch_valid;
	logic [SLOT_W-1:0]     task_index;
	logic [SLOT_COUNT-1:0] ready_mask;

	// Tracked copy of the dispatcher state, advanced at each accepted request.
	logic [INTV_W-1:0]     interval_track [SLOT_COUNT] = '{
		16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd500, 16'd100, 16'd500, 16'd3000
	};
	logic [SLOT_COUNT-1:0] ready_track = '0;
	logic [SLOT_W-1:0]     slot_track  = '0;

	// Results still owed by the dispatcher, oldest first.
	dispatch_t   pending_dispatches [$];
	int          mismatches = 0;
	int unsigned burst_left = 1;

	periodic_task_round_robin_dispatcher_top #(
		.NUM_TASKS(TASKS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.timer_value(timer_value),
		.enable_mask(enable_mask),
		.done(done),
		.dispatch_valid(dispatch_valid),
		.task_index(task_index),
		.ready_mask(ready_mask),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT) begin
			$display("MISMATCH @%0t: %s", $time, msg);
		end
	endtask

	// Advance the tracked state by one request and return the result it owes.
	function automatic dispatch_t dispatch_outcome(input logic op,
			input logic [TIMER_W-1:0] tmr, input logic [SLOT_COUNT-1:0] en);
		dispatch_t   r;
		int unsigned lim;
		int unsigned nxt;
		r = '0;
		lim = (TASKS < 1) ? 1 : ((TASKS > SLOT_COUNT) ? SLOT_COUNT : TASKS);
		if (op == OP_TICK) begin
			for (int i = 0; i < lim; i++) begin
				if (en[i] && interval_track[i] != '0 && (tmr % interval_track[i]) == '0) begin
					ready_track[i] = 1'b1;
				end
			end
		end else begin
			r.idx = slot_track;
			if (ready_track[slot_track]) begin
				r.vld = 1'b1;
				ready_track[slot_track] = 1'b0;
			end
			nxt = slot_track + 1;
			if (nxt >= lim) begin
				nxt = 0;
			end
			slot_track = nxt[SLOT_W-1:0];
		end
		r.rdy = ready_track;
		return r;
	endfunction

	// Lean toward timers that some interval divides, so flags actually get set.
	function automatic logic [TIMER_W-1:0] pick_timer();
		logic [63:0]       prod;
		logic [INTV_W-1:0] iv;
		int unsigned       sel;
		sel = $urandom_range(0, 99);
		iv = interval_track[$urandom_range(0, SLOT_COUNT - 1)];
		if (sel < 4) begin
			return '0;
		end
		if (sel < 8) begin
			return '1;
		end
		if (sel < 60 && iv != '0) begin
			prod = 64'(iv) * 64'($urandom_range(0, 32'hFFFF_FFFF / iv));
			return prod[TIMER_W-1:0];
		end
		if (sel < 75) begin
			return $urandom_range(0, 70000);
		end
		return $urandom;
	endfunction

	function automatic logic [SLOT_COUNT-1:0] pick_mask();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			return SLOT_COUNT'($urandom);
		end
		if (sel < 80) begin
			return '1;
		end
		return 8'h01 << $urandom_range(0, SLOT_COUNT - 1);
	endfunction

	// Sender idling: bursts of back-to-back requests, now and then a long
	// stretch with no idling, and gaps whose length spans a whole tick.
	function automatic int unsigned next_gap();
		int unsigned sel;
		if (burst_left > 1) begin
			burst_left--;
			return 0;
		end
		burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			return $urandom_range(1, 8);
		end
		if (sel < 95) begin
			return $urandom_range(9, 60);
		end
		return $urandom_range(61, 400);
	endfunction

	// Hold the request until the dispatcher takes it, then book its result.
	// Drop start only when a gap follows, so a back-to-back request keeps it
	// high without a second assignment in the same step.
	task automatic send_request(input logic op, input logic [TIMER_W-1:0] tmr,
			input logic [SLOT_COUNT-1:0] en, input logic typed, input dispatch_t typed_res,
			input int unsigned gap);
		dispatch_t predicted;
		start       <= 1'b1;
		operation   <= op;
		timer_value <= tmr;
		enable_mask <= en;
		@(posedge clk);
		while (busy !== 1'b0) begin
			@(posedge clk);
		end
		predicted = dispatch_outcome(op, tmr, en);
		pending_dispatches.push_back(typed ? typed_res : predicted);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Wait at falling edges so the result queue and busy are read when stable,
	// then line up on a rising edge for the next drive.
	task automatic wait_quiet();
		while (pending_dispatches.size() != 0 || busy !== 1'b0) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	task automatic write_interval(input logic [CFG_IDX_W-1:0] idx, input logic [INTV_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx < SLOT_COUNT) begin
			interval_track[idx[SLOT_W-1:0]] = val;
		end
	endtask

	// Load one interval setting into every slot, plus a write to an unused
	// index that must change nothing.
	task automatic program_plan(input interval_plan_t plan);
		logic [INTV_W-1:0] val;
		int unsigned       zero_slot;
		zero_slot = $urandom_range(0, SLOT_COUNT - 1);
		for (int s = 0; s < SLOT_COUNT; s++) begin
			case (plan)
				PLAN_MIN:       val = 16'd1;
				PLAN_MAX:       val = 16'hFFFF;
				PLAN_TINY:      val = INTV_W'($urandom_range(1, 12));
				PLAN_WIDE_ZERO: val = (s == zero_slot) ? 16'd0 : 16'($urandom_range(1, 65535));
				default:        val = INTV_W'($urandom_range(1, 1000));
			endcase
			write_interval(CFG_IDX_W'(s), val);
		end
		write_interval(CFG_IDX_W'($urandom_range(SLOT_COUNT, 2 ** CFG_IDX_W - 1)),
			INTV_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Result checker: the receiver cannot stall, so every strobe is a result.
	always @(posedge clk) begin : check_results
		dispatch_t want;
		if (arst_n && done !== 1'b0) begin
			if (pending_dispatches.size() == 0) begin
				note_mismatch($sformatf("result with none owed: valid %b slot %0d ready %02h",
					dispatch_valid, task_index, ready_mask));
			end else begin
				want = pending_dispatches.pop_front();
				if (dispatch_valid !== want.vld) begin
					note_mismatch($sformatf("dispatch_valid %b, want %b", dispatch_valid, want.vld));
				end
				if (task_index !== want.idx) begin
					note_mismatch($sformatf("task_index %0d, want %0d", task_index, want.idx));
				end
				if (ready_mask !== want.rdy) begin
					note_mismatch($sformatf("ready_mask %02h, want %02h", ready_mask, want.rdy));
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned gap;
		bit          settle;
		logic        op;
		int          waited;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// An unused index aliased onto slot 0 would make it fire on every tick
		// of the directed part.
		write_interval(CFG_IDX_W'(SLOT_COUNT), 16'd1);
		cfg_we <= 1'b0;

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			gap = next_gap();
			if (r == DIRECTED_ROWS - 1 && gap == 0) begin
				gap = 1;
			end
			send_request(DIRECTED[r].op, DIRECTED[r].timer, DIRECTED[r].mask,
				DIRECTED[r].typed, DIRECTED[r].res, gap);
		end

		// Random part: one phase per interval setting, reprogrammed only once
		// the dispatcher has drained.
		for (int p = 0; p < PLAN_COUNT; p++) begin
			wait_quiet();
			program_plan(interval_plan_t'(p));
			// open each phase with a tick that every nonzero interval divides
			send_request(OP_TICK, '0, '1, 1'b0, '0, next_gap());
			for (int n = 1; n < ITEMS_PER_PLAN; n++) begin
				gap = next_gap();
				settle = 1'b0;
				if (n == ITEMS_PER_PLAN - 1) begin
					if (gap == 0) begin
						gap = 1;
					end
				end else if ($urandom_range(0, 59) == 0) begin
					// pause until every owed result is back
					settle = 1'b1;
					if (gap == 0) begin
						gap = 1;
					end
				end
				op = ($urandom_range(0, 99) < 55) ? OP_POLL : OP_TICK;
				send_request(op, pick_timer(), pick_mask(), 1'b0, '0, gap);
				if (settle) begin
					wait_quiet();
				end
			end
		end

		// Drain with a bound, then linger to catch stray strobes.
		waited = 0;
		while (pending_dispatches.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (pending_dispatches.size() != 0) begin
			note_mismatch($sformatf("%0d results never arrived", pending_dispatches.size()));
		end
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Hard stop well past the slowest correct run.
	initial begin : watchdog
		#(64'd24_000_000);
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== periodic_task_round_robin_dispatcher_top.f =====
+incdir+sv
sv/ptrrd_pkg.sv
sv/ptrrd_rem_unit.sv
sv/periodic_task_round_robin_dispatcher_top.sv
test/tb.sv
